// ===== rtl/lgs_pkg.sv =====
// Package for the LDA Gibbs token sampler.
// Holds the item structs, sizes, register map and sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package lgs_pkg;

    localparam int MaxTopics = 16;
    localparam int MaxTerms  = 4096;
    localparam int MaxDocs   = 256;
    localparam int MaxTokens = 65536;

    localparam int KW   = $clog2(MaxTopics);       // topic index bits
    localparam int WW   = $clog2(MaxTerms);        // word index bits
    localparam int DW   = $clog2(MaxDocs);         // document index bits
    localparam int SW   = $clog2(MaxTokens);       // token slot bits
    localparam int CW   = 17;                      // count width
    localparam int NUMW = CW + 16 + 1;             // ratio numerator bits
    localparam int DENW = 38;                      // ratio denominator bits
    localparam int QW   = 17;                      // ratio and weight bits
    localparam int TOTW = QW + KW;                 // total weight bits
    localparam int PW   = 37;                      // scaled prior bits

    localparam logic [CW-1:0] CountMax = {CW{1'b1}};
    localparam logic [QW-1:0] QOne     = QW'(65536);

    // Configuration register indexes.
    localparam logic [1:0] RegNumTopics = 2'd0;
    localparam logic [1:0] RegNumTerms  = 2'd1;
    localparam logic [1:0] RegAlpha     = 2'd2;
    localparam logic [1:0] RegBeta      = 2'd3;

    // Opcodes.
    localparam logic OpInit     = 1'b0;
    localparam logic OpResample = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  doc_index;
        logic [11:0] word_id;
        logic [15:0] token_slot;
        logic [15:0] random_value;
    } in_item_t;

    typedef struct packed {
        logic [3:0] new_topic;
        logic [3:0] old_topic;
        logic       count_fault;
    } out_item_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT_MUL,
        S_TOK_RD,
        S_REM_RD,
        S_REM_WR,
        S_PRE_BV,
        S_PRE_AK,
        S_K_RD,
        S_DIV1_GO,
        S_DIV1,
        S_DIV2_GO,
        S_DIV2,
        S_WEIGHT,
        S_TARGET,
        S_SELECT,
        S_ADD_RD,
        S_ADD_WR
    } state_t;

endpackage

// ===== rtl/lgs_div.sv =====
// Iterative Q.16 ratio divider: (num << 16) / den, saturated at 1.0.
// One restoring step per cycle, 17 steps. Depends on lgs_pkg.
`timescale 1ns / 1ps

module lgs_div
    import lgs_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [NUMW-1:0] num,
    input  logic [DENW-1:0] den,
    output logic            done,
    output logic [QW-1:0]   quot
);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [4:0]      cnt_reg, cnt_next;
    logic [DENW:0]   rem_reg, rem_next;
    logic [DENW-1:0] den_reg, den_next;
    logic [QW-1:0]   q_reg, q_next;
    logic [DENW:0]   diff;
    logic            ge;
    logic [QW-1:0]   q_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    // One compare and subtract per cycle.
    always_comb
    begin
        ge        = rem_reg >= {1'b0, den_reg};
        diff      = rem_reg - {1'b0, den_reg};
        q_step    = {q_reg[QW-2:0], ge};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        if (start)
        begin
            den_next = den;
            if (den == '0)
            begin
                q_next    = '0;
                done_next = 1'b1;
            end
            else if ({5'b0, num} >= {den, 1'b0})
            begin
                q_next    = QOne;
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = (DENW+1)'(num);
                q_next    = '0;
                cnt_next  = 5'(QW);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = ge ? {diff[DENW-1:0], 1'b0} : {rem_reg[DENW-1:0], 1'b0};
            q_next   = q_step;
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (q_step > QOne)
                begin
                    q_next = QOne;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ===== rtl/lda_gibbs_token_sampler.sv =====
// Collapsed Gibbs sampler for LDA, one corpus token per item; uses lgs_pkg and lgs_div.
// Opcode 0 draws an initial topic, then reads and increments its counts. Opcode 1 reads
// and decrements the old topic's counts, then for each of K topics does a read, two divider
// passes and a weight step, then up to K select steps before the increment. Throughput: one
// item at a time; the input stalls while an item is at work or its result waits. Reset:
// control clears at once, then a clear pass zeroes the counts; no item is taken.
`timescale 1ns / 1ps

module lda_gibbs_token_sampler
    import lgs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers.
    logic [4:0]  num_topics_reg;
    logic [12:0] num_terms_reg;
    logic [23:0] alpha_reg;
    logic [23:0] beta_reg;
    logic [4:0]  k_eff;
    logic [12:0] v_eff;

    // Sequencer state.
    state_t         state_reg, state_next;
    logic [SW:0]    clr_reg, clr_next;
    logic [KW:0]    k_reg, k_next;
    logic           out_valid_reg, out_valid_next;
    out_item_t      out_item_reg, out_item_next;
    in_item_t       item_reg, item_next;
    logic           fault_reg, fault_next;
    logic [KW-1:0]  init_k_reg, init_k_next;
    logic [KW-1:0]  old_k_reg, old_k_next;
    logic [KW-1:0]  new_k_reg, new_k_next;
    logic [PW-1:0]  bv_reg, bv_next;
    logic [PW-1:0]  ak_reg, ak_next;
    logic [QW-1:0]  r1_reg, r1_next;
    logic [QW-1:0]  r2_reg, r2_next;
    logic [TOTW-1:0] total_reg, total_next;
    logic [TOTW-1:0] target_reg, target_next;
    logic [TOTW-1:0] cum_reg, cum_next;
    logic [QW-1:0]  weight_reg [MaxTopics];
    logic [CW-1:0]  tot_reg [MaxTopics];

    // Memories.
    logic [CW-1:0]  dtc_mem  [MaxDocs*MaxTopics];
    logic [CW-1:0]  twc_mem  [MaxTopics*MaxTerms];
    logic [CW-1:0]  dtot_mem [MaxDocs];
    logic [KW-1:0]  tok_mem  [MaxTokens];
    logic [CW-1:0]  dtc_rdata, twc_rdata, dtot_rdata;
    logic [KW-1:0]  tok_rdata;

    logic                  cnt_rd, cnt_we, tok_rd, tok_we;
    logic [KW-1:0]         cnt_k;
    logic [DW+KW-1:0]      dtc_waddr;
    logic [KW+WW-1:0]      twc_waddr;
    logic [DW-1:0]         dtot_waddr;
    logic [CW-1:0]         dtc_wdata, twc_wdata, dtot_wdata;
    logic                  clearing;
    logic [DW-1:0]         doc;
    logic [WW-1:0]         word;

    // Shared multiplier and divider.
    logic [23:0]     mul_a;
    logic [20:0]     mul_b;
    logic [44:0]     prod;
    logic            div_start, div_done;
    logic [NUMW-1:0] div_num;
    logic [DENW-1:0] div_den;
    logic [QW-1:0]   div_q;

    logic [KW-1:0]   ki;
    logic [TOTW-1:0] cum_sum;

    assign doc  = item_reg.doc_index[DW-1:0];
    assign word = item_reg.word_id[WW-1:0];
    assign ki   = k_reg[KW-1:0];

    // Effective topic and vocabulary sizes.
    always_comb
    begin
        k_eff = num_topics_reg;
        if (k_eff == 5'd0)
        begin
            k_eff = 5'd1;
        end
        else if (k_eff > 5'(MaxTopics))
        begin
            k_eff = 5'(MaxTopics);
        end
        v_eff = num_terms_reg;
        if (v_eff == 13'd0)
        begin
            v_eff = 13'd1;
        end
        else if (v_eff > 13'(MaxTerms))
        begin
            v_eff = 13'(MaxTerms);
        end
    end

    // APB register port.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_topics_reg <= 5'd16;
            num_terms_reg  <= 13'd4096;
            alpha_reg      <= 24'd65536;
            beta_reg       <= 24'd16;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                RegNumTopics: num_topics_reg <= pwdata[4:0];
                RegNumTerms:  num_terms_reg  <= pwdata[12:0];
                RegAlpha:     alpha_reg      <= pwdata[23:0];
                RegBeta:      beta_reg       <= pwdata[23:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            RegNumTopics: prdata = {27'b0, num_topics_reg};
            RegNumTerms:  prdata = {19'b0, num_terms_reg};
            RegAlpha:     prdata = {8'b0, alpha_reg};
            RegBeta:      prdata = {8'b0, beta_reg};
            default:      prdata = '0;
        endcase
    end

    // Shared multiplier; operands come from registers only.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_INIT_MUL:
            begin
                mul_a = {8'b0, item_reg.random_value};
                mul_b = 21'(k_eff);
            end
            S_PRE_BV:
            begin
                mul_a = beta_reg;
                mul_b = 21'(v_eff);
            end
            S_PRE_AK:
            begin
                mul_a = alpha_reg;
                mul_b = 21'(k_eff);
            end
            S_WEIGHT:
            begin
                mul_a = 24'(r1_reg);
                mul_b = 21'(r2_reg);
            end
            S_TARGET:
            begin
                mul_a = {8'b0, item_reg.random_value};
                mul_b = 21'(total_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = 45'(mul_a) * 45'(mul_b);
    end

    // Divider operands: first the topic-word ratio, then the document-topic ratio.
    always_comb
    begin
        if (state_reg == S_DIV2_GO)
        begin
            div_num = {1'b0, dtc_rdata, 16'b0} + NUMW'(alpha_reg);
            div_den = DENW'({dtot_rdata, 16'b0}) + DENW'(ak_reg);
        end
        else
        begin
            div_num = {1'b0, twc_rdata, 16'b0} + NUMW'(beta_reg);
            div_den = DENW'({tot_reg[ki], 16'b0}) + DENW'(bv_reg);
        end
        div_start = (state_reg == S_DIV1_GO) || (state_reg == S_DIV2_GO);
    end

    lgs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    // Memory read and write controls.
    always_comb
    begin
        clearing   = (state_reg == S_CLEAR);
        cnt_rd     = (state_reg == S_REM_RD) || (state_reg == S_K_RD) ||
                     (state_reg == S_ADD_RD);
        cnt_we     = clearing || (state_reg == S_REM_WR) || (state_reg == S_ADD_WR);
        tok_rd     = (state_reg == S_TOK_RD);
        tok_we     = (state_reg == S_ADD_RD);
        case (state_reg)
            S_REM_RD: cnt_k = tok_rdata;
            S_K_RD:   cnt_k = ki;
            S_REM_WR: cnt_k = old_k_reg;
            default:  cnt_k = new_k_reg;
        endcase
        if (clearing)
        begin
            dtc_waddr  = clr_reg[DW+KW-1:0];
            twc_waddr  = clr_reg[KW+WW-1:0];
            dtot_waddr = clr_reg[DW-1:0];
            dtc_wdata  = '0;
            twc_wdata  = '0;
            dtot_wdata = '0;
        end
        else
        begin
            dtc_waddr  = {doc, cnt_k};
            twc_waddr  = {cnt_k, word};
            dtot_waddr = doc;
            if (state_reg == S_REM_WR)
            begin
                dtc_wdata  = (dtc_rdata == '0) ? '0 : dtc_rdata - 1'b1;
                twc_wdata  = (twc_rdata == '0) ? '0 : twc_rdata - 1'b1;
                dtot_wdata = (dtot_rdata == '0) ? '0 : dtot_rdata - 1'b1;
            end
            else
            begin
                dtc_wdata  = (dtc_rdata == CountMax) ? CountMax : dtc_rdata + 1'b1;
                twc_wdata  = (twc_rdata == CountMax) ? CountMax : twc_rdata + 1'b1;
                dtot_wdata = (dtot_rdata == CountMax) ? CountMax : dtot_rdata + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            dtc_mem[dtc_waddr]   <= dtc_wdata;
            twc_mem[twc_waddr]   <= twc_wdata;
            dtot_mem[dtot_waddr] <= dtot_wdata;
        end
        if (cnt_rd)
        begin
            dtc_rdata  <= dtc_mem[{doc, cnt_k}];
            twc_rdata  <= twc_mem[{cnt_k, word}];
            dtot_rdata <= dtot_mem[doc];
        end
        if (tok_we)
        begin
            tok_mem[item_reg.token_slot[SW-1:0]] <= new_k_reg;
        end
        if (tok_rd)
        begin
            tok_rdata <= tok_mem[item_reg.token_slot[SW-1:0]];
        end
    end

    // Topic totals live in flip-flops and reset directly.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MaxTopics; i++)
            begin
                tot_reg[i] <= '0;
            end
        end
        else if (state_reg == S_REM_WR)
        begin
            if (tot_reg[old_k_reg] != '0)
            begin
                tot_reg[old_k_reg] <= tot_reg[old_k_reg] - 1'b1;
            end
        end
        else if (state_reg == S_ADD_WR)
        begin
            if (tot_reg[new_k_reg] != CountMax)
            begin
                tot_reg[new_k_reg] <= tot_reg[new_k_reg] + 1'b1;
            end
        end
    end

    // Per-topic weights.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_WEIGHT)
        begin
            weight_reg[ki] <= prod[QW+15:16];
        end
    end

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        out_item_reg <= out_item_next;
        item_reg     <= item_next;
        fault_reg    <= fault_next;
        init_k_reg   <= init_k_next;
        old_k_reg    <= old_k_next;
        new_k_reg    <= new_k_next;
        bv_reg       <= bv_next;
        ak_reg       <= ak_next;
        r1_reg       <= r1_next;
        r2_reg       <= r2_next;
        total_reg    <= total_next;
        target_reg   <= target_next;
        cum_reg      <= cum_next;
    end

    assign cum_sum = cum_reg + TOTW'(weight_reg[ki]);

    // Next state and datapath control.
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        item_next      = item_reg;
        fault_next     = fault_reg;
        init_k_next    = init_k_reg;
        old_k_next     = old_k_reg;
        new_k_next     = new_k_reg;
        bv_next        = bv_reg;
        ak_next        = ak_reg;
        r1_next        = r1_reg;
        r2_next        = r2_reg;
        total_next     = total_reg;
        target_next    = target_reg;
        cum_next       = cum_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (SW+1)'(MaxTokens - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && !out_valid_reg)
                begin
                    item_next  = in_item;
                    fault_next = 1'b0;
                    old_k_next = '0;
                    state_next = S_INIT_MUL;
                end
            end
            S_INIT_MUL:
            begin
                init_k_next = prod[KW+15:16];
                new_k_next  = prod[KW+15:16];
                state_next  = (item_reg.opcode == OpResample) ? S_TOK_RD : S_ADD_RD;
            end
            S_TOK_RD:
            begin
                state_next = S_REM_RD;
            end
            S_REM_RD:
            begin
                old_k_next = tok_rdata;
                state_next = S_REM_WR;
            end
            S_REM_WR:
            begin
                if (dtc_rdata == '0 || twc_rdata == '0 || dtot_rdata == '0 ||
                    tot_reg[old_k_reg] == '0)
                begin
                    fault_next = 1'b1;
                end
                state_next = S_PRE_BV;
            end
            S_PRE_BV:
            begin
                bv_next    = prod[PW-1:0];
                state_next = S_PRE_AK;
            end
            S_PRE_AK:
            begin
                ak_next    = prod[PW-1:0];
                k_next     = '0;
                total_next = '0;
                state_next = S_K_RD;
            end
            S_K_RD:
            begin
                state_next = S_DIV1_GO;
            end
            S_DIV1_GO:
            begin
                state_next = S_DIV1;
            end
            S_DIV1:
            begin
                if (div_done)
                begin
                    r1_next    = div_q;
                    state_next = S_DIV2_GO;
                end
            end
            S_DIV2_GO:
            begin
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                if (div_done)
                begin
                    r2_next    = div_q;
                    state_next = S_WEIGHT;
                end
            end
            S_WEIGHT:
            begin
                total_next = total_reg + TOTW'(prod[QW+15:16]);
                k_next     = k_reg + 1'b1;
                state_next = (k_reg + 1'b1 < k_eff) ? S_K_RD : S_TARGET;
            end
            S_TARGET:
            begin
                target_next = prod[TOTW+15:16];
                cum_next    = '0;
                k_next      = '0;
                if (total_reg == '0)
                begin
                    new_k_next = init_k_reg;
                    state_next = S_ADD_RD;
                end
                else
                begin
                    state_next = S_SELECT;
                end
            end
            S_SELECT:
            begin
                cum_next = cum_sum;
                k_next   = k_reg + 1'b1;
                if (cum_sum > target_reg || k_reg + 1'b1 >= k_eff)
                begin
                    new_k_next = ki;
                    state_next = S_ADD_RD;
                end
            end
            S_ADD_RD:
            begin
                state_next = S_ADD_WR;
            end
            S_ADD_WR:
            begin
                out_valid_next = 1'b1;
                out_item_next.new_topic   = new_k_reg;
                out_item_next.old_topic   = old_k_reg;
                out_item_next.count_fault = fault_reg ||
                    dtc_rdata == CountMax || twc_rdata == CountMax ||
                    dtot_rdata == CountMax || tot_reg[new_k_reg] == CountMax;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== rtl/lgs_checker.sv =====
// Port-level checker for the LDA Gibbs token sampler, bound to the top level.
// Depends on lgs_pkg and lda_gibbs_token_sampler.
`timescale 1ns / 1ps

module lgs_checker
    import lgs_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input in_item_t  in_item,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_item
);

    // A result held under stall stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result changed");

    // After an item is taken the block is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accept");

    // No result appears in the cycle after an item is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid)
        else $error("result too early");

    // One result per item: a delivered result is not followed at once by another.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid)
        else $error("extra result");

endmodule

bind lda_gibbs_token_sampler lgs_checker u_lgs_checker (.*);
